// ===== src/mcpwc_pkg.sv =====
// Shared types and constants for the multi-channel pulse width capture block.
// No dependencies; used by multi_channel_pulse_width_capture_top.
`default_nettype none

package mcpwc_pkg;

  // Channel slots and how many of them are sampled
  localparam int NumSlots  = 16;
  localparam int Channels  = 16;
  localparam int SlotIdxW  = $clog2(NumSlots);

  // Field widths
  localparam int TimeW     = 32;
  localparam int PinsW     = NumSlots;
  localparam int ByteW     = 8;
  localparam int TimeoutW  = 16;
  localparam int InDataW   = 48;   // now_us + pin_levels, whole bytes

  // Configuration port
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgTimeout = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgOffset  = 8'd1;

  localparam logic [TimeoutW-1:0] TimeoutRst = 16'd500;
  localparam logic [ByteW-1:0]    OffsetRst  = 8'd16;

  // Request kinds carried in tuser
  typedef enum logic {
    ReqSample  = 1'b0,
    ReqReadout = 1'b1
  } req_e;

endpackage

`default_nettype wire

// ===== src/multi_channel_pulse_width_capture_top.sv =====
// Top level of the multi-channel pulse width capture block: input register,
// per-channel pulse tracking, readout sequencer and output register.
// Depends on mcpwc_pkg.
//
//  channel   | direction | word contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tuser: req_type; tdata: now_us, pin_levels
//  m_axis    | out       | tdata: tx_byte
//  cfg       | in        | index 0 timeout_us, index 1 readout_offset
//
// One word enters per cycle. A word is held in the input register, then all
// 16 channels update in parallel (a 32-bit subtract and compare per channel)
// and a readout byte lands in the output register, which drives tvalid.
// Reset clears the active flags, widths, readout pointer, valid bits and
// configuration registers to their defaults; start times and payloads are not
// reset. A stalled output holds a readout word in the input register and
// blocks the words behind it; sample words pass every cycle otherwise.
`default_nettype none

module multi_channel_pulse_width_capture_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // stream in
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  input  wire logic [mcpwc_pkg::InDataW-1:0]        s_axis_tdata,  // [31:0] now_us,
                                                                   // [47:32] pin_levels
  input  wire logic                                 s_axis_tuser,  // [0] req_type
  // stream out
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output      logic [mcpwc_pkg::ByteW-1:0]          m_axis_tdata,  // [7:0] tx_byte
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [mcpwc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [mcpwc_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int NumSlots = mcpwc_pkg::NumSlots;
  localparam int TimeW    = mcpwc_pkg::TimeW;
  localparam int ByteW    = mcpwc_pkg::ByteW;

  // Configuration registers
  logic [mcpwc_pkg::TimeoutW-1:0] timeout_q;
  logic [ByteW-1:0]               offset_q;

  // Input register
  logic                           in_vld_q;
  mcpwc_pkg::req_e                in_req_q;
  logic [TimeW-1:0]               in_now_q;
  logic [mcpwc_pkg::PinsW-1:0]    in_pins_q;

  // Channel state; only the low byte of a width is ever read out
  logic [NumSlots-1:0]            active_q, active_d;
  logic [TimeW-1:0]               start_q [NumSlots];
  logic [TimeW-1:0]               start_d [NumSlots];
  logic [ByteW-1:0]               width_q [NumSlots];
  logic [ByteW-1:0]               width_d [NumSlots];
  logic [TimeW-1:0]               elapsed [NumSlots];

  // Readout sequencer
  logic [mcpwc_pkg::SlotIdxW-1:0] rd_idx_q, rd_idx_d;
  logic                           phase_q, phase_d;

  // Output register
  logic                           out_vld_q, out_vld_d;
  logic [ByteW-1:0]               out_byte_q, out_byte_d;

  logic out_free;
  logic in_fire;
  logic in_load;
  logic do_sample;
  logic do_readout;

  // Handshakes: the input register drains unless a readout waits on the output
  assign out_free      = !out_vld_q || m_axis_tready;
  assign do_sample     = in_vld_q && (in_req_q == mcpwc_pkg::ReqSample);
  assign do_readout    = in_vld_q && (in_req_q == mcpwc_pkg::ReqReadout) && out_free;
  assign in_fire       = do_sample || do_readout;
  assign s_axis_tready = !in_vld_q || in_fire;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign cfg_ready_o   = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= mcpwc_pkg::TimeoutRst;
      offset_q  <= mcpwc_pkg::OffsetRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == mcpwc_pkg::CfgTimeout) begin
        timeout_q <= cfg_data_i;
      end else if (cfg_index_i == mcpwc_pkg::CfgOffset) begin
        offset_q <= cfg_data_i[ByteW-1:0];
      end
    end
  end

  // Input register: valid bit under reset, payload loaded on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_req_q  <= mcpwc_pkg::req_e'(s_axis_tuser);
      in_now_q  <= s_axis_tdata[TimeW-1:0];
      in_pins_q <= s_axis_tdata[TimeW+mcpwc_pkg::PinsW-1:TimeW];
    end
  end

  // Update every sampled channel in parallel
  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      elapsed[i]  = in_now_q - start_q[i];
      active_d[i] = active_q[i];
      start_d[i]  = start_q[i];
      width_d[i]  = width_q[i];
      if (do_sample && (i < mcpwc_pkg::Channels)) begin
        if (!active_q[i]) begin
          // rising level: record start time
          if (in_pins_q[i]) begin
            active_d[i] = 1'b1;
            start_d[i]  = in_now_q;
          end
        end else begin
          // falling level: store elapsed time
          if (!in_pins_q[i]) begin
            active_d[i] = 1'b0;
            width_d[i]  = elapsed[i][ByteW-1:0];
          end
          // overlong pulse reads as zero
          if (elapsed[i] > {{(TimeW-mcpwc_pkg::TimeoutW){1'b0}}, timeout_q}) begin
            width_d[i] = '0;
          end
        end
      end
    end
  end

  // Readout: index byte, then offset width byte, then advance the index
  always_comb begin
    rd_idx_d   = rd_idx_q;
    phase_d    = phase_q;
    out_byte_d = out_byte_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    if (do_readout) begin
      out_vld_d = 1'b1;
      if (!phase_q) begin
        out_byte_d = {{(ByteW-mcpwc_pkg::SlotIdxW){1'b0}}, rd_idx_q};
        phase_d    = 1'b1;
      end else begin
        out_byte_d = width_q[rd_idx_q] + offset_q;
        rd_idx_d   = rd_idx_q + 1'b1;
        phase_d    = 1'b0;
      end
    end
  end

  // Control state and widths under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      rd_idx_q  <= '0;
      phase_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        width_q[i] <= '0;
      end
    end else begin
      active_q  <= active_d;
      rd_idx_q  <= rd_idx_d;
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
      for (int i = 0; i < NumSlots; i++) begin
        width_q[i] <= width_d[i];
      end
    end
  end

  // Start times are only read while a channel is active
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    for (int i = 0; i < NumSlots; i++) begin
      start_q[i] <= start_d[i];
    end
  end

endmodule

`default_nettype wire
